// File: design/dvrt_pkg.sv
// shared types, constants and crc helper for the distance vector route table
package dvrt_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam logic [7:0] CrcPoly = 8'h07;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_ENTRY = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;
  localparam logic [1:0] REQ_EMIT  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CRC    = 2'd1;
  localparam logic [1:0] ST_WEAK   = 2'd2;
  localparam logic [1:0] ST_SELF   = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  localparam logic [0:0] CFG_OWN  = 1'b0;
  localparam logic [0:0] CFG_RSSI = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] sender_address;
    logic [7:0] rx_level;
    logic [7:0] entry_destination;
    logic [7:0] entry_next_hop;
    logic [7:0] entry_hops;
    logic [7:0] crc_byte;
  } req_t;

  typedef struct packed {
    logic       result_kind;
    logic [1:0] status;
    logic [7:0] out_destination;
    logic [7:0] out_next_hop;
    logic [7:0] out_hops;
    logic [7:0] table_crc;
    logic [4:0] entry_total;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
  } cfg_t;

  // one byte through crc-8, msb first
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: design/dvrt_if.sv
// valid/ready channel interfaces
interface dvrt_req_if;
  import dvrt_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dvrt_rsp_if;
  import dvrt_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dvrt_cfg_if;
  import dvrt_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/distance_vector_route_table_core.sv
// top level of the distance vector route table
// Beacon start and entry items are handled at the transfer: the entry's CRC-8 over three
// bytes and the staging write happen at the transfer. A beacon end item first walks the
// table for the sender, stopping on a hit, after the last route or at the last table
// slot; then for each staged entry it passes the setup state S_STAGE and walks the
// table one route a cycle until a hit or the last route, and then gives its status. A
// rejected beacon skips both walks and gives its status directly. An emit item streams
// one route a cycle as the output is taken. Configuration writes are taken in any cycle
// and are meant to be issued only while no item is in flight.
module distance_vector_route_table_core import dvrt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  dvrt_req_if.sink req_i,
  dvrt_rsp_if.source rsp_o,
  dvrt_cfg_if.sink cfg_i
);
  logic idle, busy, reject, hit, in_acc;
  logic [3:0] cmd;
  logic [IdxW-1:0] ii, jj;
  logic [CntW-1:0] rcnt, scnt;

  // take items only when the sequencer is idle and no result is stuck
  assign req_i.ready = idle && !busy;
  assign in_acc = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  dvrt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(in_acc), .type_i(req_i.data.req_type),
    .route_cnt_i(rcnt), .staged_cnt_i(scnt), .reject_i(reject),
    .out_busy_i(busy), .hit_i(hit), .idle_o(idle), .cmd_o(cmd), .i_o(ii), .j_o(jj)
  );

  dvrt_datapath u_dp (
    .clk_i, .rst_ni,
    .in_acc_i(in_acc), .req_i(req_i.data),
    .cfg_acc_i(cfg_i.valid), .cfg_i(cfg_i.data),
    .cmd_i(cmd), .i_i(ii), .j_i(jj),
    .out_ready_i(rsp_o.ready), .out_valid_o(rsp_o.valid), .out_o(rsp_o.data),
    .out_busy_o(busy), .route_cnt_o(rcnt), .staged_cnt_o(scnt),
    .reject_o(reject), .hit_o(hit)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !rsp_o.valid || rsp_o.ready)
    else $error("accepted while result stuck");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit && !idle) |-> !in_acc)
    else $error("accepted during walk");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |=> $stable(rsp_o.data))
    else $error("held result changed");
endmodule

// File: design/dvrt_ctrl.sv
// sequencer for beacon finish and table emit
module dvrt_ctrl import dvrt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [1:0] type_i,
  input  logic [CntW-1:0] route_cnt_i,
  input  logic [CntW-1:0] staged_cnt_i,
  input  logic reject_i,
  input  logic out_busy_i,
  input  logic hit_i,
  output logic idle_o,
  output logic [3:0] cmd_o,
  output logic [IdxW-1:0] i_o,
  output logic [IdxW-1:0] j_o
);
  // cmd bits: 0 status out, 1 emit out, 2 compare step, 3 sender check
  typedef enum logic [2:0] {S_IDLE, S_SENDER, S_STAGE, S_CMP, S_STATUS, S_EMIT} state_e;
  state_e state_q;
  logic [CntW-1:0] i_q, j_q;

  assign idle_o = (state_q == S_IDLE);
  assign i_o = i_q[IdxW-1:0];
  assign j_o = j_q[IdxW-1:0];

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_SENDER: cmd_o[3] = 1'b1;
      S_CMP:    cmd_o[2] = 1'b1;
      S_STATUS: cmd_o[0] = !out_busy_i;
      S_EMIT:   cmd_o[1] = !out_busy_i;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q <= '0;
      j_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          i_q <= '0;
          j_q <= '0;
          if (start_i && type_i == REQ_END) begin
            state_q <= reject_i ? S_STATUS : S_SENDER;
          end else if (start_i && type_i == REQ_EMIT) begin
            state_q <= S_EMIT;
          end
        end
        // walk table for the sender, one entry a cycle, stop on a hit, past the last route or at the last slot
        S_SENDER: begin
          if (i_q >= route_cnt_i || i_q == CntW'(TableDepth - 1) || hit_i) begin
            i_q <= '0;
            state_q <= S_STAGE;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_STAGE: begin
          i_q <= '0;
          state_q <= (j_q >= staged_cnt_i) ? S_STATUS : S_CMP;
        end
        // one table entry per cycle against staged entry j, stop on a hit or at the last route
        S_CMP: begin
          if (hit_i || i_q + 1'b1 >= route_cnt_i) begin
            j_q <= j_q + 1'b1;
            state_q <= S_STAGE;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_STATUS: if (!out_busy_i) state_q <= S_IDLE;
        S_EMIT: begin
          if (!out_busy_i) begin
            if (i_q + 1'b1 >= route_cnt_i) state_q <= S_IDLE;
            else i_q <= i_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (j_q < staged_cnt_i))
    else $error("compare beyond staged entries");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o[0] |=> (state_q == S_IDLE))
    else $error("status not final");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (route_cnt_i == 0 || i_q < route_cnt_i))
    else $error("emit index out of range");
endmodule

// File: design/dvrt_datapath.sv
// route table, staging store, crc and output register
module dvrt_datapath import dvrt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_acc_i,
  input  req_t req_i,
  input  logic cfg_acc_i,
  input  cfg_t cfg_i,
  input  logic [3:0] cmd_i,
  input  logic [IdxW-1:0] i_i,
  input  logic [IdxW-1:0] j_i,
  input  logic out_ready_i,
  output logic out_valid_o,
  output rsp_t out_o,
  output logic out_busy_o,
  output logic [CntW-1:0] route_cnt_o,
  output logic [CntW-1:0] staged_cnt_o,
  output logic reject_o,
  output logic hit_o
);
  // tables are flops at depth 16; entries read below counts only
  logic [7:0] rdst_q [TableDepth];
  logic [7:0] rnxt_q [TableDepth];
  logic [7:0] rhop_q [TableDepth];
  logic [7:0] sdst_q [TableDepth];
  logic [7:0] shop_q [TableDepth];
  logic [CntW-1:0] rcnt_q, scnt_q;
  logic [7:0] sender_q, rssi_q, crc_q, own_q, thr_q, ecrc_q;
  logic seen_q, ovalid_q;
  logic [1:0] stat_chk;
  rsp_t out_q;
  logic [7:0] sd, sh, entry_crc;
  logic scmp_hit, stg_hit, last_cmp;

  assign route_cnt_o = rcnt_q;
  assign staged_cnt_o = scnt_q;
  assign out_valid_o = ovalid_q;
  assign out_o = out_q;
  assign out_busy_o = ovalid_q && !out_ready_i;
  assign hit_o = scmp_hit || stg_hit;

  // reject check at end-item acceptance
  always_comb begin
    stat_chk = ST_OK;
    if (seen_q && crc_q != req_i.crc_byte) stat_chk = ST_CRC;
    else if ($signed(rssi_q) < $signed(thr_q)) stat_chk = ST_WEAK;
    else if (sender_q == own_q) stat_chk = ST_SELF;
  end
  assign reject_o = (stat_chk != ST_OK);

  assign sd = sdst_q[j_i];
  assign sh = (shop_q[j_i] == 8'hFF) ? 8'hFF : shop_q[j_i] + 8'd1;
  assign scmp_hit = cmd_i[3] && ({1'b0, i_i} < rcnt_q) && rdst_q[i_i] == sender_q;
  assign stg_hit = cmd_i[2] && ((sd == own_q) ||
                   (({1'b0, i_i} < rcnt_q) && rdst_q[i_i] == sd));
  assign last_cmp = ({1'b0, i_i} + 1'b1 >= rcnt_q);
  assign entry_crc = crc_feed(crc_feed(crc_feed(ecrc_q, rdst_q[i_i]), rnxt_q[i_i]),
                              rhop_q[i_i]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q <= '0; scnt_q <= '0; sender_q <= '0; rssi_q <= '0; crc_q <= '0;
      own_q <= '0; thr_q <= '0; seen_q <= 1'b0; ovalid_q <= 1'b0;
      ecrc_q <= '0;
    end else begin
      if (cmd_i[0] || cmd_i[1]) ovalid_q <= 1'b1;
      else if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      if (cfg_acc_i && cfg_i.addr[7:1] == '0) begin
        if (cfg_i.addr[0] == CFG_OWN) own_q <= cfg_i.data;
        else thr_q <= cfg_i.data;
      end
      if (in_acc_i) begin
        case (req_i.req_type)
          REQ_START: begin
            sender_q <= req_i.sender_address; rssi_q <= req_i.rx_level;
            scnt_q <= '0; crc_q <= '0; seen_q <= 1'b0;
          end
          REQ_ENTRY: begin
            crc_q <= crc_feed(crc_feed(crc_feed(crc_q, req_i.entry_destination),
                     req_i.entry_next_hop), req_i.entry_hops);
            seen_q <= 1'b1;
            if ((req_i.entry_destination | req_i.entry_next_hop | req_i.entry_hops) != '0
                && scnt_q < CntW'(TableDepth)) begin
              sdst_q[scnt_q[IdxW-1:0]] <= req_i.entry_destination;
              shop_q[scnt_q[IdxW-1:0]] <= req_i.entry_hops;
              scnt_q <= scnt_q + 1'b1;
            end
          end
          REQ_END: begin
            out_q.status <= stat_chk;
            ecrc_q <= '0;
          end
          default: begin
            ecrc_q <= '0;
          end
        endcase
      end
      // sender pass: add neighbour when walk finishes without a hit and the table has room
      if (cmd_i[3]) begin
        if (!scmp_hit && (({1'b0, i_i} >= rcnt_q) || i_i == IdxW'(TableDepth - 1))
            && rcnt_q < CntW'(TableDepth)) begin
          rdst_q[rcnt_q[IdxW-1:0]] <= sender_q;
          rnxt_q[rcnt_q[IdxW-1:0]] <= sender_q;
          rhop_q[rcnt_q[IdxW-1:0]] <= 8'd1;
          rcnt_q <= rcnt_q + 1'b1;
        end
      end
      if (cmd_i[2]) begin
        if (sd != own_q && ({1'b0, i_i} < rcnt_q) && rdst_q[i_i] == sd
            && sh < rhop_q[i_i]) begin
          rhop_q[i_i] <= sh;
          rnxt_q[i_i] <= sender_q;
        end
        if (!stg_hit && (last_cmp || rcnt_q == 0) && rcnt_q < CntW'(TableDepth)) begin
          rdst_q[rcnt_q[IdxW-1:0]] <= sd;
          rnxt_q[rcnt_q[IdxW-1:0]] <= sender_q;
          rhop_q[rcnt_q[IdxW-1:0]] <= sh;
          rcnt_q <= rcnt_q + 1'b1;
        end
      end
      if (cmd_i[0]) begin
        out_q.result_kind <= KIND_STATUS;
        out_q.out_destination <= '0; out_q.out_next_hop <= '0;
        out_q.out_hops <= '0; out_q.table_crc <= '0;
        out_q.entry_total <= 5'(rcnt_q);
        out_q.last <= 1'b1;
        scnt_q <= '0; crc_q <= '0; seen_q <= 1'b0;
      end
      if (cmd_i[1]) begin
        out_q.result_kind <= KIND_ENTRY;
        out_q.status <= ST_OK;
        out_q.entry_total <= 5'(rcnt_q);
        if (rcnt_q == 0) begin
          out_q.out_destination <= '0; out_q.out_next_hop <= '0;
          out_q.out_hops <= '0; out_q.table_crc <= '0; out_q.last <= 1'b1;
        end else begin
          out_q.out_destination <= rdst_q[i_i];
          out_q.out_next_hop <= rnxt_q[i_i];
          out_q.out_hops <= rhop_q[i_i];
          out_q.table_crc <= entry_crc;
          ecrc_q <= entry_crc;
          out_q.last <= last_cmp;
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rcnt_q <= CntW'(TableDepth)) && (scnt_q <= CntW'(TableDepth)))
    else $error("count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ready_i) |=> ovalid_q)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i[0] |=> !seen_q && scnt_q == 0)
    else $error("staging not cleared");
endmodule
